// ===== src/bsf_pkg.sv =====
package bsf_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_WRITE,
    ST_READ,
    ST_RESULT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic apply;
    logic wr_step;
    logic rd_step;
    logic deliver;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic wr_needed;
    logic wr_last;
    logic rd_last;
  } ctl_stat_t;

endpackage

// ===== src/byte_stream_fifo.sv =====
// Byte stream buffer: one ring memory, one byte written or read per cycle.
// A request is accepted in idle, applied in update, written byte by byte into
// the ring (pushes only), then read back for the front bytes before the strobe.
// A new request is taken only once the last one is done (busy), set by the single
// byte-wide write and read ports of the ring. Results cannot be stalled.
// Reset (rst, synchronous) empties the buffer, clears totals and closed flag.
module byte_stream_fifo #(
  parameter int DEPTH = 4096,
  parameter int LANES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [63:0] data_bytes,
  input  logic [3:0]  push_len,
  input  logic [12:0] pop_len,
  input  logic        cfg_we,
  input  logic [12:0] cfg_data,
  output logic        done,
  output logic [12:0] accepted_len,
  output logic [63:0] front_bytes,
  output logic [3:0]  front_count,
  output logic [12:0] buffered,
  output logic [12:0] available,
  output logic [63:0] total_pushed,
  output logic [63:0] total_popped,
  output logic        stream_closed,
  output logic        finished
);

  import bsf_pkg::*;

  ctl_cmd_t  ctl;
  ctl_stat_t stat;

  bsf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctl   (ctl),
    .stat  (stat)
  );

  bsf_datapath #(
    .DEPTH (DEPTH),
    .LANES (LANES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .cmd           (cmd),
    .data_bytes    (data_bytes),
    .push_len      (push_len),
    .pop_len       (pop_len),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .accepted_len  (accepted_len),
    .front_bytes   (front_bytes),
    .front_count   (front_count),
    .buffered      (buffered),
    .available     (available),
    .total_pushed  (total_pushed),
    .total_popped  (total_popped),
    .stream_closed (stream_closed),
    .finished      (finished)
  );

  assign done = ctl.deliver;

endmodule

// ===== src/bsf_ram.sv =====
module bsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/bsf_ctrl.sv =====
module bsf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output bsf_pkg::ctl_cmd_t  ctl,
  input  bsf_pkg::ctl_stat_t stat
);

  import bsf_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load   = 1'b1;
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        ctl.apply  = 1'b1;
        state_next = stat.wr_needed ? ST_WRITE : ST_READ;
      end
      ST_WRITE: begin
        ctl.wr_step = 1'b1;
        if (stat.wr_last) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        ctl.rd_step = 1'b1;
        if (stat.rd_last) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        ctl.deliver = 1'b1;
        state_next  = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_to_update: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_UPDATE))
    else $error("accepted request did not enter update");

  a_result_pulse: assert property (@(posedge clk) disable iff (rst)
    ctl.deliver |=> (!ctl.deliver && !busy))
    else $error("result strobe longer than one cycle");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.load, ctl.apply, ctl.wr_step, ctl.rd_step, ctl.deliver}))
    else $error("more than one datapath command at once");
`endif

endmodule

// ===== src/bsf_datapath.sv =====
module bsf_datapath #(
  parameter int DEPTH = 4096,
  parameter int LANES = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  bsf_pkg::ctl_cmd_t  ctl,
  output bsf_pkg::ctl_stat_t stat,
  input  logic [1:0]         cmd,
  input  logic [63:0]        data_bytes,
  input  logic [3:0]         push_len,
  input  logic [12:0]        pop_len,
  input  logic               cfg_we,
  input  logic [12:0]        cfg_data,
  output logic [12:0]        accepted_len,
  output logic [63:0]        front_bytes,
  output logic [3:0]         front_count,
  output logic [12:0]        buffered,
  output logic [12:0]        available,
  output logic [63:0]        total_pushed,
  output logic [63:0]        total_popped,
  output logic               stream_closed,
  output logic               finished
);

  import bsf_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 13) ? CW : 13;
  localparam int LW = $clog2(LANES + 1);
  localparam int FW = LANES * 8;

  // architectural state
  logic [12:0]   capacity;
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] wr_ptr;
  logic [CW-1:0] count;
  logic [63:0]   pushed;
  logic [63:0]   popped;
  logic          closed;

  // per-request working registers
  cmd_t          cmd_q;
  logic [FW-1:0] data_q;
  logic [CW-1:0] take;
  logic [LW-1:0] widx;
  logic [LW-1:0] ridx;
  logic [LW-1:0] fcount;
  logic [AW-1:0] scan_ptr;
  logic [FW-1:0] front;

  logic [CW-1:0] eff_cap;
  logic [CW-1:0] room;
  logic [3:0]    dlen_c;
  logic [CW-1:0] take_in;
  logic [CW-1:0] count_next;
  logic [AW:0]   rd_sum;
  logic [AW-1:0] rd_adv;
  logic [7:0]    rdata;
  logic [7:0]    cap_byte;

  always_comb begin
    eff_cap = (XW'(capacity) > XW'(DEPTH)) ? CW'(DEPTH) : CW'(capacity);
    room    = (eff_cap > count) ? (eff_cap - count) : '0;
    dlen_c  = (push_len > 4'(LANES)) ? 4'(LANES) : push_len;
    if (cmd_t'(cmd) == CMD_PUSH) begin
      take_in = (CW'(dlen_c) < room) ? CW'(dlen_c) : room;
    end else if (cmd_t'(cmd) == CMD_POP) begin
      take_in = (XW'(pop_len) < XW'(count)) ? CW'(pop_len) : count;
    end else begin
      take_in = '0;
    end
    case (cmd_q)
      CMD_PUSH: count_next = count + take;
      CMD_POP:  count_next = count - take;
      default:  count_next = count;
    endcase
    // take never exceeds DEPTH, so one conditional subtract wraps the pointer
    rd_sum = (AW + 1)'(rd_ptr) + (AW + 1)'(take);
    rd_adv = (rd_sum >= (AW + 1)'(DEPTH)) ? AW'(rd_sum - (AW + 1)'(DEPTH)) : AW'(rd_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= 13'd4096;
      rd_ptr   <= '0;
      wr_ptr   <= '0;
      count    <= '0;
      pushed   <= '0;
      popped   <= '0;
      closed   <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (ctl.apply) begin
        count <= count_next;
        if (cmd_q == CMD_PUSH) begin
          pushed <= pushed + 64'(take);
        end
        if (cmd_q == CMD_POP) begin
          popped <= popped + 64'(take);
          rd_ptr <= rd_adv;
        end
        if (cmd_q == CMD_CLOSE) begin
          closed <= 1'b1;
        end
      end
      if (ctl.wr_step) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q  <= cmd_t'(cmd);
      data_q <= FW'(data_bytes);
      take   <= take_in;
      widx   <= '0;
      ridx   <= '0;
      front  <= '0;
    end
    if (ctl.apply) begin
      scan_ptr <= (cmd_q == CMD_POP) ? rd_adv : rd_ptr;
      fcount   <= (count_next < CW'(LANES)) ? LW'(count_next) : LW'(LANES);
    end
    if (ctl.wr_step) begin
      data_q <= data_q >> 8;
      widx   <= widx + 1'b1;
    end
    if (ctl.rd_step) begin
      ridx <= ridx + 1'b1;
      if (ridx < LW'(LANES)) begin
        scan_ptr <= (scan_ptr == AW'(DEPTH - 1)) ? '0 : scan_ptr + 1'b1;
      end
      // read data comes from the ring's registered output, so it arrives the cycle after its address
      if (ridx != '0) begin
        front <= (front >> 8) | (FW'(cap_byte) << (FW - 8));
      end
    end
  end

  assign cap_byte = ((ridx - 1'b1) < fcount) ? rdata : 8'd0;

  bsf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ctl.wr_step),
    .waddr (wr_ptr),
    .wdata (data_q[7:0]),
    .re    (ctl.rd_step && (ridx < LW'(LANES))),
    .raddr (scan_ptr),
    .rdata (rdata)
  );

  always_comb begin
    stat.wr_needed = (cmd_q == CMD_PUSH) && (take != '0);
    stat.wr_last   = (CW'(widx) == (take - 1'b1));
    stat.rd_last   = (ridx == LW'(LANES));
  end

  assign accepted_len  = 13'(take);
  assign front_bytes   = 64'(front);
  assign front_count   = 4'(fcount);
  assign buffered      = 13'(count);
  assign available     = 13'(room);
  assign total_pushed  = pushed;
  assign total_popped  = popped;
  assign stream_closed = closed;
  assign finished      = closed && (count == '0);

`ifndef ASSERT_OFF
  logic [AW:0] ptr_gap;
  assign ptr_gap = (wr_ptr >= rd_ptr) ? (AW + 1)'(wr_ptr - rd_ptr)
                                      : (AW + 1)'(wr_ptr) + (AW + 1)'(DEPTH) - (AW + 1)'(rd_ptr);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill level above ring depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    ctl.deliver |-> (ptr_gap == ((count == CW'(DEPTH)) ? '0 : (AW + 1)'(count))))
    else $error("ring pointers disagree with fill level");

  a_write_fits: assert property (@(posedge clk) disable iff (rst)
    ctl.wr_step |-> (CW'(widx) < take))
    else $error("ring write beyond accepted length");
`endif

endmodule
